// ===== rtl/core/spq_pkg.sv =====
// Package with the shared types and constants of the stable priority queue.
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int ITEM_W       = 32;
  localparam int PRIO_W       = 16;
  localparam int COUNT_OUT_W  = 5;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_e_t;

  // One slot of the sorted chain.
  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [ITEM_W-1:0]        item;
  } spq_entry_t;

  // Operation broadcast to every cell in the cycle a word is accepted.
  typedef struct packed {
    logic                     push_en;
    logic                     pop_en;
    logic signed [PRIO_W-1:0] key;
    logic [ITEM_W-1:0]        item;
  } spq_op_t;

  localparam spq_entry_t EMPTY_ENTRY = '{valid: 1'b0, prio: '0, item: '0};

endpackage

// ===== rtl/core/stable_priority_queue_top.sv =====
// Top level of the stable priority queue: a chain of sorted cells and a result register.
//
// The block keeps up to CAPACITY entries (item handle and signed priority) in
// a row of cells sorted head first. The smallest priority is the head, and
// equal priorities leave in arrival order.
// Input channel: in_valid/in_stall with one request word made of req_type,
// item_handle and priority_req. A push inserts an entry, a pop removes the
// head. A push into a full queue is dropped and flagged, a pop of an empty
// queue changes nothing and is flagged.
// Output channel: out_valid/out_stall, one result word per request carrying
// the head after the request, the count and the two flags.
// The result is registered: the word accepted at one edge shows its result
// after that edge. One request is accepted per cycle while in_stall is low;
// every cell updates in the accept cycle, so the rate is set by the single
// broadcast insert/shift step. While the result register holds a word that
// the receiver stalls, in_stall is raised and the chain holds still.
// Reset (rst_n low, synchronous) empties the queue and the result register.
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic [ITEM_W-1:0]        in_item_handle,
  input  logic signed [PRIO_W-1:0] in_priority_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_head_valid,
  output logic [ITEM_W-1:0]        out_head_item,
  output logic signed [PRIO_W-1:0] out_head_priority,
  output logic [COUNT_OUT_W-1:0]   out_entry_count,
  output logic                     out_push_dropped,
  output logic                     out_pop_on_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_entry_t cell_q   [CAPACITY];
  spq_entry_t cell_d   [CAPACITY];
  logic       cell_shift [CAPACITY];

  spq_op_t    op;
  logic       accept;
  logic       is_push;
  logic       is_full;
  logic       is_empty;
  logic       drop;
  logic       empty_pop;

  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

  logic                     out_valid_r;
  logic                     head_valid_r;
  logic [ITEM_W-1:0]        head_item_r;
  logic signed [PRIO_W-1:0] head_prio_r;
  logic [COUNT_OUT_W-1:0]   count_out_r;
  logic                     dropped_r;
  logic                     empty_pop_r;

  // The result register is the only buffer, so a new word is taken whenever
  // that register is free or is being emptied in the same cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_push  = (in_req_type == REQ_PUSH);

  // Full and empty are read straight from the ends of the chain.
  assign is_full   = cell_q[CAPACITY-1].valid;
  assign is_empty  = !cell_q[0].valid;
  assign drop      = is_push && is_full;
  assign empty_pop = !is_push && is_empty;

  assign op.push_en = accept && is_push && !is_full;
  assign op.pop_en  = accept && !is_push && !is_empty;
  assign op.key     = in_priority_req;
  assign op.item    = in_item_handle;

  // Each cell sees its left neighbor for inserts and its right neighbor for
  // pops; the head cell has no left neighbor and the tail reads an empty slot.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left_e;
    logic       left_s;
    spq_entry_t right_e;

    if (i == 0) begin : g_head
      assign left_e = EMPTY_ENTRY;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_s = cell_shift[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = EMPTY_ENTRY;
    end else begin : g_body
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .left_entry  (left_e),
      .left_shift  (left_s),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .shift       (cell_shift[i]),
      .entry_nxt   (cell_d[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (op.push_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // The reported count is the count after the request, cut to the output width.
  assign count_wide = (CNT_W + COUNT_OUT_W)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The head after the request is the next value of the first cell.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_valid_r <= cell_d[0].valid;
      head_item_r  <= cell_d[0].valid ? cell_d[0].item : '0;
      head_prio_r  <= cell_d[0].valid ? cell_d[0].prio : '0;
      count_out_r  <= count_wide[COUNT_OUT_W-1:0];
      dropped_r    <= drop;
      empty_pop_r  <= empty_pop;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_head_valid    = head_valid_r;
  assign out_head_item     = head_item_r;
  assign out_head_priority = head_prio_r;
  assign out_entry_count   = count_out_r;
  assign out_push_dropped  = dropped_r;
  assign out_pop_on_empty  = empty_pop_r;

endmodule

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain with its insert and shift logic.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  spq_op_t    op,
  input  spq_entry_t left_entry,
  input  logic       left_shift,
  input  spq_entry_t right_entry,
  output spq_entry_t entry,
  output logic       shift,
  output spq_entry_t entry_nxt
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [PRIO_W-1:0] prio_r;
  logic signed [PRIO_W-1:0] prio_nxt;
  logic [ITEM_W-1:0]        item_r;
  logic [ITEM_W-1:0]        item_nxt;

  // A slot moves right on a push when it is empty or strictly larger than the
  // new key, so equal priorities keep their arrival order.
  assign shift = !valid_r || (prio_r > op.key);

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    item_nxt  = item_r;
    if (op.push_en && shift) begin
      if (left_shift) begin
        valid_nxt = left_entry.valid;
        prio_nxt  = left_entry.prio;
        item_nxt  = left_entry.item;
      end else begin
        valid_nxt = 1'b1;
        prio_nxt  = op.key;
        item_nxt  = op.item;
      end
    end else if (op.pop_en) begin
      valid_nxt = right_entry.valid;
      prio_nxt  = right_entry.prio;
      item_nxt  = right_entry.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    item_r <= item_nxt;
  end

  assign entry     = '{valid: valid_r, prio: prio_r, item: item_r};
  assign entry_nxt = '{valid: valid_nxt, prio: prio_nxt, item: item_nxt};

endmodule

// ===== rtl/core/spq_checker.sv =====
// Port-level checker for the stable priority queue and its bind statement.
module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_head_valid,
  input logic [ITEM_W-1:0]        out_head_item,
  input logic signed [PRIO_W-1:0] out_head_priority,
  input logic [COUNT_OUT_W-1:0]   out_entry_count,
  input logic                     out_push_dropped,
  input logic                     out_pop_on_empty
);

  localparam logic [COUNT_OUT_W-1:0] FULL_COUNT = COUNT_OUT_W'(CAPACITY);

  // A stalled result word stays valid and keeps its head item, priority and count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_head_item)
      && $stable(out_head_priority) && $stable(out_entry_count))
    else $error("stalled result word changed");

  // A dropped push only happens at full capacity.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_push_dropped |-> out_entry_count == FULL_COUNT
      && out_head_valid)
    else $error("push dropped while not full");

  // An empty pop leaves the queue empty with a zero head.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pop_on_empty |-> !out_head_valid
      && out_entry_count == '0 && out_head_item == '0)
    else $error("empty pop reported a non-empty queue");

  // No head means no entries, a zero head priority and no dropped push.
  a_no_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |-> out_entry_count == '0
      && out_head_priority == '0 && !out_push_dropped)
    else $error("empty head with inconsistent fields");

  // Both flags never show in the same word.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_push_dropped && out_pop_on_empty))
    else $error("drop and empty-pop flagged together");

endmodule

bind stable_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
